// ===== sv/ptw_pkg.sv =====
// ============================================================================
// ptw_pkg
// Shared types and constants for the x86 page table walker: request and
// result payloads, walk level codes and configuration register indexes.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package ptw_pkg;

    localparam int VIRT_W = 32;
    localparam int ENTRY_W = 64;
    localparam int ADDR_W = 48;
    localparam int PERM_W = 2;
    localparam int CFG_IDX_W = 4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TABLE_ROOT = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAE_MODE = 4'd1;

    // Request actions
    localparam logic ACT_TRANSLATE = 1'b0;
    localparam logic ACT_MEM_DATA = 1'b1;

    // Result kinds
    localparam logic KIND_READ = 1'b0;
    localparam logic KIND_DONE = 1'b1;

    // Walk level: which table entry the walker waits for
    typedef enum logic [1:0] {
        LVL_IDLE = 2'd0,
        LVL_PDPT = 2'd1,
        LVL_DIR  = 2'd2,
        LVL_TBL  = 2'd3
    } walk_level_t;

    typedef struct packed {
        logic               action;
        logic [VIRT_W-1:0]  virt_addr;
        logic [ENTRY_W-1:0] mem_data;
    } ptw_in_t;

    typedef struct packed {
        logic              kind;
        logic [ADDR_W-1:0] read_addr;
        logic              read_wide;
        logic [ADDR_W-1:0] phys_addr;
        logic [PERM_W-1:0] perms;
        logic              fault;
    } ptw_out_t;

endpackage

`default_nettype wire

// ===== sv/x86_page_table_walker.sv =====
// ============================================================================
// x86_page_table_walker
// Walks two-level (4-byte entry) or PAE (three-level, 8-byte entry) x86 page
// tables for a 32-bit virtual address, one request per step.
// ============================================================================
// Result: a request's result (read request or finished translation) is
//   valid in the output register in the cycle after the request is accepted.
// Throughput: one request per cycle; the output register is the only stage,
//   and a new request is taken whenever it is empty or being drained.
// Reset (aresetn low, synchronous): walker idle, permission accumulator all
//   ones, table root and PAE mode cleared, output register empty.
`timescale 1ns / 1ps
`default_nettype none

module x86_page_table_walker #(
    parameter int PHYS_ADDR_BITS = 48
) (
    input  wire                                    aclk,
    input  wire                                    aresetn,
    // request channel
    input  wire                                    s_valid,
    output logic                                   s_ready,
    input  wire  ptw_pkg::ptw_in_t                 s_data,
    // result channel
    output logic                                   m_valid,
    input  wire                                    m_ready,
    output ptw_pkg::ptw_out_t                      m_data,
    // configuration write channel
    input  wire                                    cfg_valid,
    output logic                                   cfg_ready,
    input  wire  [ptw_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  wire  [ptw_pkg::ADDR_W-1:0]             cfg_data
);

    localparam int AW = ptw_pkg::ADDR_W;

    // Entry address mask: physical address bits above the 4 KiB page offset.
    // Only the low 48 bits matter since every address leaves masked to 48.
    localparam logic [63:0] PAGE_MASK_FULL =
        ((64'd1 << PHYS_ADDR_BITS) - 64'd1) & ~64'd4095;
    localparam logic [AW-1:0] PAGE_MASK = PAGE_MASK_FULL[AW-1:0];

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    logic [AW-1:0]                  table_root_reg;
    logic                           pae_mode_reg;
    ptw_pkg::walk_level_t           lvl_reg, lvl_next;
    logic [ptw_pkg::VIRT_W-1:0]     saved_virt_reg, saved_virt_next;
    logic [2:0]                     perm_acc_reg, perm_acc_next;
    logic                           out_valid_reg, out_valid_next;
    ptw_pkg::ptw_out_t              out_reg, out_next;

    logic                           accept;
    logic                           res_valid;
    ptw_pkg::ptw_out_t              res;

    // Entry as seen at this step: a two-level walk uses only the low word,
    // the PAE pointer level always uses the full entry.
    logic [ptw_pkg::ENTRY_W-1:0]    entry;
    logic [AW-1:0]                  entry_base;
    logic                           present;
    logic                           large_page;
    logic [2:0]                     perm_and;
    logic [ptw_pkg::VIRT_W-1:0]     sv;
    logic [ptw_pkg::VIRT_W-1:0]     nv;

    // Config writes always land at once.
    assign cfg_ready = 1'b1;

    // Take a request whenever the output register is free or draining.
    assign s_ready = !out_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    assign sv = saved_virt_reg;
    assign nv = s_data.virt_addr;

    assign entry = (lvl_reg != ptw_pkg::LVL_PDPT && !pae_mode_reg)
                 ? {32'd0, s_data.mem_data[31:0]} : s_data.mem_data;
    assign entry_base = entry[AW-1:0] & PAGE_MASK;
    assign present    = entry[0];
    assign large_page = entry[7];
    assign perm_and   = perm_acc_reg & entry[2:0];

    // ------------------------------------------------------------------
    // Next walk state
    // ------------------------------------------------------------------
    always_comb begin
        lvl_next        = lvl_reg;
        saved_virt_next = saved_virt_reg;
        perm_acc_next   = perm_acc_reg;
        if (s_data.action == ptw_pkg::ACT_TRANSLATE) begin
            // start only from idle; drop a start that arrives mid-walk
            if (lvl_reg == ptw_pkg::LVL_IDLE) begin
                saved_virt_next = nv;
                perm_acc_next   = 3'b111;
                lvl_next        = pae_mode_reg ? ptw_pkg::LVL_PDPT : ptw_pkg::LVL_DIR;
            end
        end else begin
            case (lvl_reg)
                ptw_pkg::LVL_IDLE: begin
                    // drop stray memory data
                end
                ptw_pkg::LVL_PDPT: begin
                    lvl_next = present ? ptw_pkg::LVL_DIR : ptw_pkg::LVL_IDLE;
                end
                ptw_pkg::LVL_DIR: begin
                    if (present) begin
                        perm_acc_next = perm_and;
                        lvl_next = large_page ? ptw_pkg::LVL_IDLE : ptw_pkg::LVL_TBL;
                    end else begin
                        lvl_next = ptw_pkg::LVL_IDLE;
                    end
                end
                ptw_pkg::LVL_TBL: begin
                    if (present) begin
                        perm_acc_next = perm_and;
                    end
                    lvl_next = ptw_pkg::LVL_IDLE;
                end
                default: begin
                    lvl_next = ptw_pkg::LVL_IDLE;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Result for the request at the input
    // ------------------------------------------------------------------
    always_comb begin
        res       = '0;
        res_valid = 1'b0;
        if (s_data.action == ptw_pkg::ACT_TRANSLATE) begin
            if (lvl_reg == ptw_pkg::LVL_IDLE) begin
                res_valid = 1'b1;
                res.kind  = ptw_pkg::KIND_READ;
                if (pae_mode_reg) begin
                    // PDPT is 32-byte aligned, four 8-byte pointers
                    res.read_addr = {table_root_reg[AW-1:5], 5'd0}
                                  + {{(AW-5){1'b0}}, nv[31:30], 3'd0};
                    res.read_wide = 1'b1;
                end else begin
                    res.read_addr = (table_root_reg & PAGE_MASK)
                                  + {{(AW-12){1'b0}}, nv[31:22], 2'd0};
                    res.read_wide = 1'b0;
                end
            end
        end else begin
            case (lvl_reg)
                ptw_pkg::LVL_IDLE: begin
                    res_valid = 1'b0;
                end
                ptw_pkg::LVL_PDPT: begin
                    res_valid = 1'b1;
                    if (present) begin
                        res.kind      = ptw_pkg::KIND_READ;
                        res.read_addr = entry_base + {{(AW-12){1'b0}}, sv[29:21], 3'd0};
                        res.read_wide = 1'b1;
                    end else begin
                        res.kind  = ptw_pkg::KIND_DONE;
                        res.fault = 1'b1;
                    end
                end
                ptw_pkg::LVL_DIR: begin
                    res_valid = 1'b1;
                    if (!present) begin
                        res.kind  = ptw_pkg::KIND_DONE;
                        res.fault = 1'b1;
                    end else if (large_page) begin
                        // large page: keep frame bits, splice in the offset
                        res.kind  = ptw_pkg::KIND_DONE;
                        res.perms = perm_and[2:1];
                        if (pae_mode_reg) begin
                            res.phys_addr = {entry_base[AW-1:21], sv[20:0]};
                        end else begin
                            res.phys_addr = {entry_base[AW-1:22], sv[21:0]};
                        end
                    end else begin
                        res.kind = ptw_pkg::KIND_READ;
                        if (pae_mode_reg) begin
                            res.read_addr = entry_base
                                          + {{(AW-12){1'b0}}, sv[20:12], 3'd0};
                            res.read_wide = 1'b1;
                        end else begin
                            res.read_addr = entry_base
                                          + {{(AW-12){1'b0}}, sv[21:12], 2'd0};
                            res.read_wide = 1'b0;
                        end
                    end
                end
                ptw_pkg::LVL_TBL: begin
                    res_valid = 1'b1;
                    res.kind  = ptw_pkg::KIND_DONE;
                    if (present) begin
                        res.phys_addr = {entry_base[AW-1:12], sv[11:0]};
                        res.perms     = perm_and[2:1];
                    end else begin
                        res.fault = 1'b1;
                    end
                end
                default: begin
                    res_valid = 1'b0;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Output register: load on a result, hold while stalled, drop on take
    // ------------------------------------------------------------------
    always_comb begin
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !m_ready;
        if (accept && res_valid) begin
            out_next       = res;
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lvl_reg        <= ptw_pkg::LVL_IDLE;
            saved_virt_reg <= '0;
            perm_acc_reg   <= 3'b111;
            out_valid_reg  <= 1'b0;
            table_root_reg <= '0;
            pae_mode_reg   <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (accept) begin
                lvl_reg        <= lvl_next;
                saved_virt_reg <= saved_virt_next;
                perm_acc_reg   <= perm_acc_next;
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    ptw_pkg::CFG_TABLE_ROOT: table_root_reg <= cfg_data;
                    ptw_pkg::CFG_PAE_MODE:   pae_mode_reg   <= cfg_data[0];
                    default: begin
                        // unknown index: ignore
                    end
                endcase
            end
        end
    end

    // payload needs no reset
    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

endmodule

`default_nettype wire

// ===== sim/x86_page_table_walker_tb.sv =====
// ============================================================================
// x86_page_table_walker_tb
// Self-checking bench for the page table walker. It drives translate and
// memory-data requests, keeps its own model of the walk (level, saved
// address, permission AND, root and PAE mode), and compares every result
// field by field against the oldest predicted one. Two-level and PAE walks,
// faults, large pages, out-of-turn requests and a mode change in the middle
// of a walk are covered directly, then random walks run under several
// sender and receiver idling mixes.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module x86_page_table_walker_tb;

    localparam int PHYS_ADDR_BITS = 48;
    localparam logic [63:0] PAGE_MASK = ((64'd1 << PHYS_ADDR_BITS) - 64'd1) & ~64'd4095;
    localparam logic [ptw_pkg::ADDR_W-1:0] ROOT_MAX = {ptw_pkg::ADDR_W{1'b1}};

    logic aclk = 1'b0;
    logic aresetn = 1'b0;

    logic              s_valid = 1'b0;
    logic              s_ready;
    ptw_pkg::ptw_in_t  s_data = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    ptw_pkg::ptw_out_t m_data;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [ptw_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [ptw_pkg::ADDR_W-1:0]    cfg_data = '0;

    // Walker model state and its copy of the registers
    ptw_pkg::walk_level_t       model_level = ptw_pkg::LVL_IDLE;
    logic [ptw_pkg::VIRT_W-1:0] model_virt = '0;
    logic [2:0]                 model_perm = 3'b111;
    logic [ptw_pkg::ADDR_W-1:0] model_root = '0;
    logic                       model_pae = 1'b0;

    ptw_pkg::ptw_out_t pending_walk_results[$];
    ptw_pkg::ptw_out_t oldest_result;
    int walk_results_predicted = 0;
    int mismatch_count = 0;

    // Idling mix, in percent of cycles
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    x86_page_table_walker #(
        .PHYS_ADDR_BITS(PHYS_ADDR_BITS)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data(s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data(m_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #5 aclk = ~aclk;

    // Stall the result channel at the current rate
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic report_mismatch(input string msg);
        $display("%0t: mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    function automatic ptw_pkg::ptw_out_t read_result(input logic [63:0] addr,
                                                      input logic wide);
        ptw_pkg::ptw_out_t r;
        r = '0;
        r.kind = ptw_pkg::KIND_READ;
        r.read_addr = addr[ptw_pkg::ADDR_W-1:0];
        r.read_wide = wide;
        return r;
    endfunction

    // A fault clears the address and permissions
    function automatic ptw_pkg::ptw_out_t done_result(input logic [63:0] phys,
                                                      input logic [1:0] perms,
                                                      input logic fault);
        ptw_pkg::ptw_out_t r;
        r = '0;
        r.kind = ptw_pkg::KIND_DONE;
        r.phys_addr = fault ? '0 : phys[ptw_pkg::ADDR_W-1:0];
        r.perms = fault ? '0 : perms;
        r.fault = fault;
        return r;
    endfunction

    // Advance the walk model by one accepted request and queue its result
    task automatic predict_walk_step(input ptw_pkg::ptw_in_t req);
        logic [63:0] entry;
        logic [63:0] span;
        logic [63:0] base;
        ptw_pkg::ptw_out_t res;
        bit has_res;
        has_res = 1'b0;
        if (req.action == ptw_pkg::ACT_TRANSLATE) begin
            // drop a start while a walk is in progress
            if (model_level == ptw_pkg::LVL_IDLE) begin
                has_res = 1'b1;
                model_virt = req.virt_addr;
                model_perm = 3'b111;
                if (model_pae) begin
                    model_level = ptw_pkg::LVL_PDPT;
                    res = read_result((64'(model_root) & ~64'd31) + 64'(model_virt[31:30]) * 8,
                                      1'b1);
                end else begin
                    model_level = ptw_pkg::LVL_DIR;
                    res = read_result((64'(model_root) & PAGE_MASK)
                                      + 64'(model_virt[31:22]) * 4, 1'b0);
                end
            end
        end else if (model_level != ptw_pkg::LVL_IDLE) begin
            has_res = 1'b1;
            entry = req.mem_data;
            if (model_level == ptw_pkg::LVL_PDPT) begin
                // pointer entry: present bit only, no permissions
                if (!entry[0]) begin
                    res = done_result('0, '0, 1'b1);
                end else begin
                    model_level = ptw_pkg::LVL_DIR;
                    res = read_result((entry & PAGE_MASK) + 64'(model_virt[29:21]) * 8, 1'b1);
                end
            end else begin
                if (!model_pae) entry[63:32] = '0;
                if (!entry[0]) begin
                    res = done_result('0, '0, 1'b1);
                end else begin
                    model_perm &= entry[2:0];
                    if (model_level == ptw_pkg::LVL_DIR && entry[7]) begin
                        // large page: keep the offset inside the page
                        span = model_pae ? (64'd1 << 21) : (64'd1 << 22);
                        base = entry & PAGE_MASK & ~(span - 64'd1);
                        res = done_result(base + (64'(model_virt) & (span - 64'd1)),
                                          model_perm[2:1], 1'b0);
                    end else if (model_level == ptw_pkg::LVL_DIR) begin
                        model_level = ptw_pkg::LVL_TBL;
                        if (model_pae)
                            res = read_result((entry & PAGE_MASK)
                                              + 64'(model_virt[20:12]) * 8, 1'b1);
                        else
                            res = read_result((entry & PAGE_MASK)
                                              + 64'(model_virt[21:12]) * 4, 1'b0);
                    end else begin
                        res = done_result((entry & PAGE_MASK) + 64'(model_virt[11:0]),
                                          model_perm[2:1], 1'b0);
                    end
                end
            end
        end
        if (has_res) begin
            if (res.kind == ptw_pkg::KIND_DONE) model_level = ptw_pkg::LVL_IDLE;
            pending_walk_results.push_back(res);
            walk_results_predicted++;
        end
    endtask

    // Send one request; hold valid and payload until it is taken
    task automatic send_request(input ptw_pkg::ptw_in_t req);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= req;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_walk_step(req);
    endtask

    task automatic send_translate(input logic [ptw_pkg::VIRT_W-1:0] va);
        ptw_pkg::ptw_in_t req;
        req = '0;
        req.action = ptw_pkg::ACT_TRANSLATE;
        req.virt_addr = va;
        send_request(req);
    endtask

    task automatic send_entry(input logic [ptw_pkg::ENTRY_W-1:0] entry);
        ptw_pkg::ptw_in_t req;
        req = '0;
        req.action = ptw_pkg::ACT_MEM_DATA;
        req.mem_data = entry;
        send_request(req);
    endtask

    // Lower valid and wait until every predicted result has come back,
    // then wait on for a dropped request still in flight
    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_walk_results.size() != 0) @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    task automatic write_register(input logic [ptw_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [ptw_pkg::ADDR_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        if (idx == ptw_pkg::CFG_TABLE_ROOT)
            model_root = value;
        else if (idx == ptw_pkg::CFG_PAE_MODE)
            model_pae = value[0];
        @(posedge aclk);
    endtask

    // Two-level walks from the reset settings (root 0)
    task automatic test_two_level_walks();
        send_translate(32'hFFFF_FFFF);
        send_translate(32'h0000_0000);              // start while busy: dropped
        send_entry(64'hFFFF_FFFF_FFFF_FF7F);        // upper half ignored, no large page
        send_entry(64'hFFFF_FFFF_FFFF_FFFF);        // table entry, full permissions
        send_entry(64'h0000_0000_0000_0000);        // data while idle: dropped
        send_translate(32'h0000_0000);
        send_entry(64'h0000_0000_0000_0000);        // directory not present
        send_translate(32'h1234_5678);
        send_entry(64'hABCD_0000_FFC0_0083);        // 4 MiB page, write only
        send_translate(32'h0040_1ABC);
        send_entry(64'h0000_0000_0000_1005);        // user, read only
        send_entry(64'h0000_0000_0000_0000);        // table entry not present
    endtask

    // PAE walks from the highest root
    task automatic test_pae_walks();
        wait_drained();
        write_register(ptw_pkg::CFG_TABLE_ROOT, ROOT_MAX);
        write_register(ptw_pkg::CFG_PAE_MODE, ROOT_MAX);     // only bit 0 counts
        send_translate(32'hFFFF_FFFF);
        send_entry(64'h0000_0000_0000_0000);        // pointer entry not present
        send_translate(32'hC000_0000);
        send_entry(64'hFFFF_FFFF_FFFF_FFFF);        // pointer entry ignores bit 7
        send_entry(64'hFFFF_FFFF_FFFF_FFFF);        // 2 MiB page
        send_translate(32'h0000_0000);
        send_entry(64'h0000_0000_0000_0001);
        send_entry(64'h8000_0000_0000_0003);
        send_entry(64'h8FFF_FFFF_FFFF_F005);
    endtask

    // Switch PAE off while the walker waits for a directory entry
    task automatic test_config_mid_walk();
        wait_drained();
        write_register(ptw_pkg::CFG_TABLE_ROOT, '0);
        send_translate(32'h8020_3456);
        send_entry(64'h0000_0000_0000_0001);
        wait_drained();
        write_register(ptw_pkg::CFG_PAE_MODE, 48'hFFFF_FFFF_FFFE);
        send_entry(64'hFFFF_FFFF_0000_0007);        // now treated as a 32-bit entry
        send_entry(64'h0000_0000_00AB_C007);
    endtask

    // Random walks: mostly well-formed with random entries, some requests
    // out of turn. Stop once the phase has predicted its share of results.
    task automatic test_random_walks(input int idle_pct, input int stall_pct,
                                     input logic [ptw_pkg::ADDR_W-1:0] root,
                                     input logic pae, input int result_goal);
        ptw_pkg::ptw_in_t req;
        bit noise;
        int goal;
        wait_drained();
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        write_register(ptw_pkg::CFG_TABLE_ROOT, root);
        write_register(ptw_pkg::CFG_PAE_MODE,
                       48'({$urandom, $urandom}) & ~48'd1 | 48'(pae));
        goal = walk_results_predicted + result_goal;
        while (walk_results_predicted < goal) begin
            // now and then hold off until the walker has answered everything
            if ($urandom_range(49) == 0) wait_drained();
            req.virt_addr = $urandom;
            req.mem_data = {$urandom, $urandom};
            noise = ($urandom_range(9) == 0);
            if (model_level == ptw_pkg::LVL_IDLE) begin
                req.action = noise ? ptw_pkg::ACT_MEM_DATA : ptw_pkg::ACT_TRANSLATE;
            end else begin
                req.action = noise ? ptw_pkg::ACT_TRANSLATE : ptw_pkg::ACT_MEM_DATA;
                req.mem_data[0] = ($urandom_range(9) != 0);
                req.mem_data[7] = ($urandom_range(2) == 0);
            end
            send_request(req);
        end
    endtask

    // Compare each accepted result with the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_walk_results.size() == 0) begin
                report_mismatch($sformatf("result with nothing pending: %h", m_data));
            end else begin
                oldest_result = pending_walk_results.pop_front();
                if (m_data.kind !== oldest_result.kind)
                    report_mismatch($sformatf("kind %h, want %h",
                                              m_data.kind, oldest_result.kind));
                if (m_data.read_addr !== oldest_result.read_addr)
                    report_mismatch($sformatf("read_addr %h, want %h",
                                              m_data.read_addr, oldest_result.read_addr));
                if (m_data.read_wide !== oldest_result.read_wide)
                    report_mismatch($sformatf("read_wide %h, want %h",
                                              m_data.read_wide, oldest_result.read_wide));
                if (m_data.phys_addr !== oldest_result.phys_addr)
                    report_mismatch($sformatf("phys_addr %h, want %h",
                                              m_data.phys_addr, oldest_result.phys_addr));
                if (m_data.perms !== oldest_result.perms)
                    report_mismatch($sformatf("perms %h, want %h",
                                              m_data.perms, oldest_result.perms));
                if (m_data.fault !== oldest_result.fault)
                    report_mismatch($sformatf("fault %h, want %h",
                                              m_data.fault, oldest_result.fault));
            end
        end
    end

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_two_level_walks();
        test_pae_walks();
        test_config_mid_walk();
        test_random_walks(0, 0, '0, 1'b0, 95);
        test_random_walks(53, 0, ROOT_MAX, 1'b1, 95);
        test_random_walks(0, 53, 48'({$urandom, $urandom}), 1'($urandom), 95);
        test_random_walks(21, 21, 48'({$urandom, $urandom}), 1'($urandom), 95);

        // Let the last results drain, then give a dropped request time to settle
        wait_drained();
        repeat (5) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("[x86_page_table_walker] OK");
        end else begin
            $display("[x86_page_table_walker] ERROR");
        end
        $finish;
    end

    // Guard against a hung handshake
    initial begin
        #2_000_000;
        $display("[x86_page_table_walker] ERROR");
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
sv/ptw_pkg.sv
sv/x86_page_table_walker.sv
sim/x86_page_table_walker_tb.sv
